// ===== src/point_in_polygon_ray_cast_top_defines.svh =====
// Assertion macros for the point-in-polygon block
`ifndef POINT_IN_POLYGON_RAY_CAST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CAST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define PIPR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pipr: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent
`define PIPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pipr: next-cycle check failed");
`else
`define PIPR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PIPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/pipr_pkg.sv =====
package pipr_pkg;

   // Result codes
   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_OUTSIDE  = 2'd0;
   localparam verdict_type VERDICT_INSIDE   = 2'd1;
   localparam verdict_type VERDICT_BOUNDARY = 2'd2;
   localparam verdict_type VERDICT_SHORT    = 2'd3;

   // Vertex count, saturating at three
   typedef logic [1:0] count_type;
   localparam count_type COUNT_EMPTY = 2'd0;
   localparam count_type COUNT_ONE   = 2'd1;
   localparam count_type COUNT_FULL  = 2'd3;

   // Slots of the four products formed for one edge
   typedef logic [1:0] prod_sel_type;
   localparam prod_sel_type PROD_CROSS_A = 2'd0;
   localparam prod_sel_type PROD_CROSS_B = 2'd1;
   localparam prod_sel_type PROD_RAY_A   = 2'd2;
   localparam prod_sel_type PROD_RAY_B   = 2'd3;

   // Per-edge flags that travel alongside the products
   typedef struct packed {
      logic active;    // edge is tested on this request
      logic in_box;    // query point inside the edge bounding box
      logic straddle;  // edge spans the ray's y level
      logic rise;      // start point y above end point y
   } edge_flags_type;

   // Per-edge outcome
   typedef struct packed {
      logic on_edge;
      logic toggle;
   } edge_result_type;

endpackage

// ===== src/pipr_edge_prod.sv =====
// Edge from (xj,yj) to (xi,yi): differences, exact products and flags
module pipr_edge_prod #(
   parameter int COORD_BITS = 24
) (
   input  logic signed [COORD_BITS-1:0]   xi,
   input  logic signed [COORD_BITS-1:0]   yi,
   input  logic signed [COORD_BITS-1:0]   xj,
   input  logic signed [COORD_BITS-1:0]   yj,
   input  logic signed [COORD_BITS-1:0]   qx,
   input  logic signed [COORD_BITS-1:0]   qy,
   input  logic                           active,
   output pipr_pkg::edge_flags_type       flags,
   output logic signed [2*COORD_BITS+1:0] prod [4]
);
   import pipr_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;

   logic signed [DIFF_BITS-1:0] dx_ij, dy_qj, dy_ij, dx_qj;
   logic signed [DIFF_BITS-1:0] dx_qi, dy_ji, dx_ji, dy_qi;
   logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;

   // Form coordinate differences one bit wider than the inputs
   always_comb begin
      dx_ij = DIFF_BITS'(xi) - DIFF_BITS'(xj);
      dy_qj = DIFF_BITS'(qy) - DIFF_BITS'(yj);
      dy_ij = DIFF_BITS'(yi) - DIFF_BITS'(yj);
      dx_qj = DIFF_BITS'(qx) - DIFF_BITS'(xj);
      dx_qi = DIFF_BITS'(qx) - DIFF_BITS'(xi);
      dy_ji = DIFF_BITS'(yj) - DIFF_BITS'(yi);
      dx_ji = DIFF_BITS'(xj) - DIFF_BITS'(xi);
      dy_qi = DIFF_BITS'(qy) - DIFF_BITS'(yi);
   end

   // Cross product terms for the collinearity test and the ray crossing
   always_comb begin
      prod[PROD_CROSS_A] = dx_ij * dy_qj;
      prod[PROD_CROSS_B] = dy_ij * dx_qj;
      prod[PROD_RAY_A]   = dx_qi * dy_ji;
      prod[PROD_RAY_B]   = dx_ji * dy_qi;
   end

   // Bounding box, ray span and edge direction
   always_comb begin
      lo_x = (xi < xj) ? xi : xj;
      hi_x = (xi < xj) ? xj : xi;
      lo_y = (yi < yj) ? yi : yj;
      hi_y = (yi < yj) ? yj : yi;
      flags.active   = active;
      flags.in_box   = (qx >= lo_x) && (qx <= hi_x) && (qy >= lo_y) && (qy <= hi_y);
      flags.straddle = (yi > qy) != (yj > qy);
      flags.rise     = yj > yi;
   end

endmodule

// ===== src/pipr_edge_eval.sv =====
// Compare registered products: on-edge test first, then ray crossing
module pipr_edge_eval #(
   parameter int COORD_BITS = 24
) (
   input  pipr_pkg::edge_flags_type       flags,
   input  logic signed [2*COORD_BITS+1:0] prod [4],
   output pipr_pkg::edge_result_type      result
);
   import pipr_pkg::*;

   logic collinear;
   logic ray_hit;

   always_comb begin
      collinear = prod[PROD_CROSS_A] == prod[PROD_CROSS_B];
      // Sign of the edge height picks the direction of the comparison
      ray_hit   = flags.rise ? (prod[PROD_RAY_A] < prod[PROD_RAY_B])
                             : (prod[PROD_RAY_A] > prod[PROD_RAY_B]);
      result.on_edge = flags.active && flags.in_box && collinear;
      result.toggle  = flags.active && !result.on_edge && flags.straddle && ray_hit;
   end

endmodule

// ===== src/point_in_polygon_ray_cast_top.sv =====
// Channel  Direction  Handshake        Payload
// req      in         valid / stall    vertex_x, vertex_y, query_x, query_y, last_vertex
// rsp      out        valid / stall    verdict (one per request with last_vertex set)
//
// One request per cycle, back to back, while req_stall is low. An accepted request moves
// through the input register and the product register; a last vertex then loads the result
// register, raising rsp_valid. Reset (synchronous, active high) empties the pipeline and
// starts a new polygon. A stalled verdict holds the result register; requests with no
// verdict still drain, and req_stall rises only when a verdict waits.
`include "point_in_polygon_ray_cast_top_defines.svh"

module point_in_polygon_ray_cast_top #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic signed [COORD_BITS-1:0] req_query_x,
   input  logic signed [COORD_BITS-1:0] req_query_y,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pipr_pkg::verdict_type        rsp_verdict
);
   import pipr_pkg::*;

   localparam int PROD_BITS = 2 * (COORD_BITS + 1);

   // Polygon state
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_BITS-1:0] query_x_ff, query_y_ff;
   logic signed [COORD_BITS-1:0] first_x_in, first_y_in, query_x_in, query_y_in;
   count_type                    seen_ff, seen_in, count_in;
   logic                         new_poly;
   logic                         req_accept;

   // Input register
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_new_ff, s1_last_ff;
   count_type                    s1_count_ff;
   logic signed [COORD_BITS-1:0] s1_vx_ff, s1_vy_ff, s1_px_ff, s1_py_ff;
   logic signed [COORD_BITS-1:0] s1_fx_ff, s1_fy_ff, s1_qx_ff, s1_qy_ff;

   // Product register
   logic                         s2_valid_ff, s2_valid_in;
   logic                         s2_new_ff, s2_last_ff, s2_vmatch_ff, s2_vmatch_in;
   count_type                    s2_count_ff;
   edge_flags_type               s2_main_flags_ff, s2_close_flags_ff;
   edge_flags_type               main_flags_in, close_flags_in;
   logic signed [PROD_BITS-1:0]  s2_main_prod_ff [4];
   logic signed [PROD_BITS-1:0]  s2_close_prod_ff [4];
   logic signed [PROD_BITS-1:0]  main_prod_in [4];
   logic signed [PROD_BITS-1:0]  close_prod_in [4];

   // Accumulators and result register
   logic                         parity_ff, parity_in, boundary_ff, boundary_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   verdict_type                  rsp_verdict_ff, rsp_verdict_in;
   edge_result_type              main_res, close_res;

   // Flow control
   logic                         out_free, s2_leave, s2_ready, s1_move, s1_ready;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s2_leave  = s2_valid_ff && (!s2_last_ff || out_free);
      s2_ready  = !s2_valid_ff || s2_leave;
      s1_move   = s1_valid_ff && s2_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
      req_stall = !s1_ready;
      req_accept = req_valid && !req_stall;
   end

   // Latch first vertex and query point on a new polygon; count vertices
   always_comb begin
      new_poly   = seen_ff == COUNT_EMPTY;
      first_x_in = new_poly ? req_vertex_x : first_x_ff;
      first_y_in = new_poly ? req_vertex_y : first_y_ff;
      query_x_in = new_poly ? req_query_x  : query_x_ff;
      query_y_in = new_poly ? req_query_y  : query_y_ff;
      count_in   = (seen_ff == COUNT_FULL) ? COUNT_FULL : seen_ff + COUNT_ONE;
      seen_in    = req_last_vertex ? COUNT_EMPTY : count_in;
   end

   // Valid bits of the pipeline
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_leave) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
      if (s2_leave && s2_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Edge from previous to current vertex; skipped on the first vertex
   pipr_edge_prod #(.COORD_BITS(COORD_BITS)) u_main_prod (
      .xi     (s1_vx_ff),
      .yi     (s1_vy_ff),
      .xj     (s1_px_ff),
      .yj     (s1_py_ff),
      .qx     (s1_qx_ff),
      .qy     (s1_qy_ff),
      .active (!s1_new_ff),
      .flags  (main_flags_in),
      .prod   (main_prod_in)
   );

   // Closing edge from current back to first vertex; only on the last vertex
   pipr_edge_prod #(.COORD_BITS(COORD_BITS)) u_close_prod (
      .xi     (s1_fx_ff),
      .yi     (s1_fy_ff),
      .xj     (s1_vx_ff),
      .yj     (s1_vy_ff),
      .qx     (s1_qx_ff),
      .qy     (s1_qy_ff),
      .active (s1_last_ff),
      .flags  (close_flags_in),
      .prod   (close_prod_in)
   );

   assign s2_vmatch_in = (s1_vx_ff == s1_qx_ff) && (s1_vy_ff == s1_qy_ff);

   pipr_edge_eval #(.COORD_BITS(COORD_BITS)) u_main_eval (
      .flags  (s2_main_flags_ff),
      .prod   (s2_main_prod_ff),
      .result (main_res)
   );

   pipr_edge_eval #(.COORD_BITS(COORD_BITS)) u_close_eval (
      .flags  (s2_close_flags_ff),
      .prod   (s2_close_prod_ff),
      .result (close_res)
   );

   // Fold edge outcomes into parity and boundary; form the verdict
   always_comb begin
      parity_in   = (s2_new_ff ? 1'b0 : parity_ff) ^ main_res.toggle ^ close_res.toggle;
      boundary_in = (s2_new_ff ? 1'b0 : boundary_ff) | main_res.on_edge
                    | close_res.on_edge | s2_vmatch_ff;
      if (s2_count_ff != COUNT_FULL) begin
         rsp_verdict_in = VERDICT_SHORT;
      end else if (boundary_in) begin
         rsp_verdict_in = VERDICT_BOUNDARY;
      end else if (parity_in) begin
         rsp_verdict_in = VERDICT_INSIDE;
      end else begin
         rsp_verdict_in = VERDICT_OUTSIDE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= COUNT_EMPTY;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         parity_ff    <= 1'b0;
         boundary_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            seen_ff <= seen_in;
         end
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_leave) begin
            parity_ff   <= parity_in;
            boundary_ff <= boundary_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         query_x_ff  <= query_x_in;
         query_y_ff  <= query_y_in;
         prev_x_ff   <= req_vertex_x;
         prev_y_ff   <= req_vertex_y;
         s1_new_ff   <= new_poly;
         s1_last_ff  <= req_last_vertex;
         s1_count_ff <= count_in;
         s1_vx_ff    <= req_vertex_x;
         s1_vy_ff    <= req_vertex_y;
         s1_px_ff    <= prev_x_ff;
         s1_py_ff    <= prev_y_ff;
         s1_fx_ff    <= first_x_in;
         s1_fy_ff    <= first_y_in;
         s1_qx_ff    <= query_x_in;
         s1_qy_ff    <= query_y_in;
      end
      if (s1_move) begin
         s2_new_ff         <= s1_new_ff;
         s2_last_ff        <= s1_last_ff;
         s2_count_ff       <= s1_count_ff;
         s2_vmatch_ff      <= s2_vmatch_in;
         s2_main_flags_ff  <= main_flags_in;
         s2_close_flags_ff <= close_flags_in;
         s2_main_prod_ff   <= main_prod_in;
         s2_close_prod_ff  <= close_prod_in;
      end
      if (s2_leave && s2_last_ff) begin
         rsp_verdict_ff <= rsp_verdict_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // Checks
   `PIPR_ASSERT_NEXT(a_last_clears_count, clock, reset, req_accept && req_last_vertex, seen_ff == COUNT_EMPTY)
   `PIPR_ASSERT_NOW(a_new_poly_count, clock, reset, s1_valid_ff && s1_new_ff, s1_count_ff == COUNT_ONE)
   `PIPR_ASSERT_NOW(a_empty_front_takes, clock, reset, !s1_valid_ff, !req_stall)
   `PIPR_ASSERT_NEXT(a_last_gives_result, clock, reset, s2_leave && s2_last_ff, rsp_valid_ff)

endmodule

// ===== tb/tb_point_in_polygon_ray_cast_top.sv =====
module tb_point_in_polygon_ray_cast_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pipr_pkg::*;

   localparam int COORD_W = 24;
   localparam int TOTAL_VERTICES = 700;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int REPORT_LIMIT = 10;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef struct {
      coord_type x;
      coord_type y;
   } vertex_type;

   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   // Tracks the open polygon and queues the verdict each closing vertex yields
   class polygon_verdict_board;
      longint anchor_x, anchor_y, last_x, last_y, probe_x, probe_y;
      bit parity;
      bit on_boundary;
      count_type seen;
      verdict_type pending_verdicts[$];
      int failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         anchor_x = 0;
         anchor_y = 0;
         last_x = 0;
         last_y = 0;
         probe_x = 0;
         probe_y = 0;
         parity = 1'b0;
         on_boundary = 1'b0;
         seen = COUNT_EMPTY;
      endfunction

      // Append one expected verdict behind those still outstanding
      function void queue_verdict(verdict_type v);
         pending_verdicts = {pending_verdicts, v};
      endfunction

      // Test the edge from (xj,yj) to (xi,yi) against the latched query point
      function void classify_edge(longint xi, longint yi, longint xj, longint yj);
         longint lox, hix, loy, hiy, dy, lhs, rhs;
         bit hit;
         lox = (xi < xj) ? xi : xj;
         hix = (xi < xj) ? xj : xi;
         loy = (yi < yj) ? yi : yj;
         hiy = (yi < yj) ? yj : yi;
         // collinear and inside the inclusive bounding box: on the edge
         if ((xi - xj) * (probe_y - yj) == (yi - yj) * (probe_x - xj) &&
             probe_x >= lox && probe_x <= hix && probe_y >= loy && probe_y <= hiy) begin
            on_boundary = 1'b1;
            return;
         end
         // edge spans the ray level: compare without dividing
         if ((yi > probe_y) != (yj > probe_y)) begin
            dy = yj - yi;
            lhs = (probe_x - xi) * dy;
            rhs = (xj - xi) * (probe_y - yi);
            hit = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
            if (hit) parity = ~parity;
         end
      endfunction

      function void note_request(coord_type vx, coord_type vy, coord_type qx, coord_type qy,
                                 logic closing);
         longint px, py;
         px = vx;
         py = vy;
         // latch the query point on the opening vertex
         if (seen == COUNT_EMPTY) begin
            probe_x = qx;
            probe_y = qy;
            anchor_x = px;
            anchor_y = py;
            parity = 1'b0;
            on_boundary = 1'b0;
         end else begin
            classify_edge(px, py, last_x, last_y);
         end
         if (px == probe_x && py == probe_y) on_boundary = 1'b1;
         if (seen != COUNT_FULL) seen = seen + COUNT_ONE;
         last_x = px;
         last_y = py;
         if (closing) begin
            classify_edge(anchor_x, anchor_y, px, py);
            if (seen != COUNT_FULL) queue_verdict(VERDICT_SHORT);
            else if (on_boundary) queue_verdict(VERDICT_BOUNDARY);
            else if (parity) queue_verdict(VERDICT_INSIDE);
            else queue_verdict(VERDICT_OUTSIDE);
            restart();
         end
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= REPORT_LIMIT) $display("[%0t] %s", $time, what);
      endfunction

      function void check_result(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            note_failure($sformatf("verdict %0d with none outstanding", got));
            return;
         end
         want = pending_verdicts.pop_front();
         if (got !== want)
            note_failure($sformatf("verdict mismatch: expected %0d, got %0d", want, got));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   coord_type   req_vertex_x = '0;
   coord_type   req_vertex_y = '0;
   coord_type   req_query_x = '0;
   coord_type   req_query_y = '0;
   logic        req_last_vertex = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   verdict_type rsp_verdict;

   polygon_verdict_board board;
   vertex_type outline[$];
   int  sent_count = 0;
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   bit  hold_request = 1'b0;

   point_in_polygon_ray_cast_top #(
      .COORD_BITS(COORD_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y),
      .req_query_x(req_query_x),
      .req_query_y(req_query_y),
      .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_verdict(rsp_verdict)
   );

   always #1 clock = ~clock;

   function automatic coord_type random_coord(int span);
      if (span == 0) return coord_type'($urandom());
      return coord_type'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic void add_vertex(coord_type vx, coord_type vy);
      vertex_type v;
      v.x = vx;
      v.y = vy;
      outline = {outline, v};
   endfunction

   // Offer one vertex, idling first at random, and hold it until taken
   task automatic offer_vertex(coord_type vx, coord_type vy, coord_type qx, coord_type qy,
                               logic closing);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_query_x <= qx;
      req_query_y <= qy;
      req_last_vertex <= closing;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(vx, vy, qx, qy, closing);
      sent_count++;
   endtask

   // Send the outline as one polygon; optionally vary the query after the first vertex
   task automatic offer_outline(coord_type qx, coord_type qy, bit wander);
      for (int i = 0; i < outline.size(); i++) begin
         offer_vertex(outline[i].x, outline[i].y,
                      (i == 0 || !wander) ? qx : random_coord(0),
                      (i == 0 || !wander) ? qy : random_coord(0),
                      i == outline.size() - 1);
      end
   endtask

   task automatic offer_directed();
      // lone vertex on the query point: still too short
      outline.delete();
      add_vertex(0, 0);
      offer_outline(0, 0, 1'b0);
      // two extreme vertices with the query on the segment
      outline.delete();
      add_vertex(COORD_MIN, COORD_MIN);
      add_vertex(COORD_MAX, COORD_MAX);
      offer_outline(0, 0, 1'b0);
      // square: inside, then far outside
      outline.delete();
      add_vertex(0, 0);
      add_vertex(10, 0);
      add_vertex(10, 10);
      add_vertex(0, 10);
      offer_outline(5, 5, 1'b0);
      offer_outline(COORD_MAX, COORD_MIN, 1'b0);
      // query on the closing edge only
      outline.delete();
      add_vertex(0, 0);
      add_vertex(10, 0);
      add_vertex(0, 10);
      offer_outline(0, 5, 1'b0);
      // query on a corner, later query fields changing
      outline.delete();
      add_vertex(COORD_MIN, COORD_MIN);
      add_vertex(COORD_MAX, COORD_MIN);
      add_vertex(COORD_MAX, COORD_MAX);
      offer_outline(COORD_MAX, COORD_MIN, 1'b1);
      // widest triangle around the origin
      outline.delete();
      add_vertex(COORD_MIN, COORD_MIN);
      add_vertex(COORD_MAX, COORD_MIN);
      add_vertex(0, COORD_MAX);
      offer_outline(0, 0, 1'b1);
   endtask

   // Random polygon: mostly small coordinates so edges and crossings are hit often
   task automatic offer_random_polygon();
      int n, span, pick, k;
      coord_type qx, qy;
      pick = $urandom_range(99);
      if (pick < 10) n = $urandom_range(2, 1);
      else if (pick < 15) n = $urandom_range(20, 12);
      else n = $urandom_range(8, 3);
      pick = $urandom_range(99);
      span = (pick < 50) ? 8 : ((pick < 75) ? 1000 : 0);
      outline.delete();
      for (int i = 0; i < n; i++) add_vertex(random_coord(span), random_coord(span));
      // query on a vertex, near an edge midpoint, or anywhere
      pick = $urandom_range(99);
      k = $urandom_range(n - 1);
      if (pick < 20) begin
         qx = outline[k].x;
         qy = outline[k].y;
      end else if (pick < 35) begin
         qx = coord_type'((longint'(outline[k].x) + outline[(k + 1) % n].x) / 2);
         qy = coord_type'((longint'(outline[k].y) + outline[(k + 1) % n].y) / 2);
      end else begin
         qx = random_coord(span);
         qy = random_coord(span);
      end
      offer_outline(qx, qy, 1'($urandom_range(1)));
   endtask

   // Result side: check accepted verdicts, stall at random or for a long hold
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_verdict);
         if (hold_request) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      offer_directed();
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 25 : ((phase == 1) ? 57 : 0);
         receiver_idle_pct = (phase == 0) ? 57 : ((phase == 1) ? 25 : 0);
         // back up the pipeline while requests keep coming
         if (phase == 2) hold_request = 1'b1;
         while (sent_count < (phase + 1) * TOTAL_VERTICES / 3) offer_random_polygon();
      end
      req_valid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pending_verdicts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #200000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/pipr_pkg.sv
src/pipr_edge_prod.sv
src/pipr_edge_eval.sv
src/point_in_polygon_ray_cast_top.sv
tb/tb_point_in_polygon_ray_cast_top.sv
